[design/sfr_pkg.sv]
// Shared types and constants of the frame receiver.
package sfr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int ST_W   = 2;

   // Default store depth in bytes.
   localparam int MAX_PAYLOAD_DEF = 64;

   // Command queue depth between front and back.
   localparam int QDEPTH = 2;

   // Header bytes.
   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h06;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h85;

   // Length register reset value.
   localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

   // Result status codes.
   localparam logic [ST_W-1:0] ST_GOOD     = 2'd0;
   localparam logic [ST_W-1:0] ST_CSUM_ERR = 2'd1;
   localparam logic [ST_W-1:0] ST_LEN_ERR  = 2'd2;

   // One command from front to back: replay (good status) or error.
   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [LEN_W-1:0] len;
   } cmd_type;

endpackage

[design/sfr_if.sv]
// Handshake interfaces of the received byte and result channels.
interface sfr_req_if;
   logic                     valid;
   logic                     ready;
   logic [sfr_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sfr_pkg::BYTE_W-1:0] payload_byte;
   logic                       is_last;
   logic [sfr_pkg::ST_W-1:0]   status;

   modport source (output valid, output payload_byte, output is_last, output status,
                   input ready);
   modport sink   (input valid, input payload_byte, input is_last, input status,
                   output ready);
endinterface

[design/sfr_front.sv]
// Front end: header hunt, length check, payload capture and checksum compare.
module sfr_front #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
   parameter int AW          = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   sfr_req_if.sink                     req,
   input  logic                        csr_we,
   input  logic [sfr_pkg::LEN_W-1:0]   csr_wdata,
   output logic                        cmd_push,
   output sfr_pkg::cmd_type            cmd_data,
   input  logic                        cmd_full,
   input  logic                        replay_done,
   output logic                        mem_we,
   output logic [AW-1:0]               mem_waddr,
   output logic [sfr_pkg::BYTE_W-1:0]  mem_wdata
);

   localparam logic [7:0] MaxW = 8'(MAX_PAYLOAD);

   typedef enum logic [4:0] {
      PH_HUNT0 = 5'b00001,
      PH_HUNT1 = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_CSUM  = 5'b10000
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [sfr_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [sfr_pkg::LEN_W-1:0]   cnt_ff, cnt_in;
   logic [sfr_pkg::BYTE_W-1:0]  xor_ff, xor_in;
   logic [AW-1:0]               waddr_ff, waddr_in;
   logic                        pend_ff, pend_in;
   logic                        accept;
   logic                        len_ok;
   logic [sfr_pkg::BYTE_W-1:0]  b;
   logic [sfr_pkg::LEN_W-1:0]   cnt_inc;

   // Stall only while a replay is owed or the queue is full.
   assign req.ready = !pend_ff && !cmd_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;
   assign len_ok    = (len_ff != '0) && ({1'b0, len_ff} <= MaxW);
   assign cnt_inc   = cnt_ff + 1'b1;

   assign mem_waddr = waddr_ff;
   assign mem_wdata = b;

   // Frame state machine
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      xor_in   = xor_ff;
      waddr_in = waddr_ff;
      pend_in  = pend_ff;
      cmd_push = 1'b0;
      cmd_data = '{status: sfr_pkg::ST_GOOD, len: len_ff};
      mem_we   = 1'b0;

      if (replay_done) begin
         pend_in = 1'b0;
      end

      if (csr_we) begin
         len_in   = csr_wdata;
         phase_in = PH_HUNT0;
         cnt_in   = '0;
         xor_in   = '0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_HUNT0: begin
               if (b == sfr_pkg::HDR_FIRST) phase_in = PH_HUNT1;
            end
            PH_HUNT1: begin
               phase_in = (b == sfr_pkg::HDR_SECOND) ? PH_LEN : PH_HUNT0;
            end
            PH_LEN: begin
               if (len_ok && (b == {1'b0, len_ff})) begin
                  phase_in = PH_DATA;
                  cnt_in   = '0;
                  waddr_in = '0;
                  xor_in   = b;
               end else begin
                  cmd_push        = 1'b1;
                  cmd_data.status = sfr_pkg::ST_LEN_ERR;
                  phase_in        = PH_HUNT0;
                  cnt_in          = '0;
                  xor_in          = '0;
               end
            end
            PH_DATA: begin
               mem_we   = 1'b1;
               xor_in   = xor_ff ^ b;
               cnt_in   = cnt_inc;
               waddr_in = waddr_ff + 1'b1;
               if (cnt_inc >= len_ff) phase_in = PH_CSUM;
            end
            PH_CSUM: begin
               cmd_push = 1'b1;
               if ((b == xor_ff) && len_ok) begin
                  cmd_data.status = sfr_pkg::ST_GOOD;
                  pend_in         = 1'b1;
               end else begin
                  cmd_data.status = sfr_pkg::ST_CSUM_ERR;
               end
               phase_in = PH_HUNT0;
               cnt_in   = '0;
               xor_in   = '0;
            end
            default: begin
               phase_in = PH_HUNT0;
               cnt_in   = '0;
               xor_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         len_ff   <= sfr_pkg::LEN_RESET;
         cnt_ff   <= '0;
         xor_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         xor_ff   <= xor_in;
         pend_ff  <= pend_in;
      end
   end

   // Store write address, meaningful only inside a frame
   always_ff @(posedge clock) begin
      waddr_ff <= waddr_in;
   end

endmodule

[design/sfr_cmd_queue.sv]
// Short command queue between the front end and the replay back end.
module sfr_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             avail,
   output sfr_pkg::cmd_type pop_data
);

   localparam int PW = (sfr_pkg::QDEPTH > 1) ? $clog2(sfr_pkg::QDEPTH) : 1;
   localparam int CW = $clog2(sfr_pkg::QDEPTH + 1);
   localparam logic [CW-1:0] DepthC = CW'(sfr_pkg::QDEPTH);
   localparam logic [PW-1:0] LastP  = PW'(sfr_pkg::QDEPTH - 1);

   sfr_pkg::cmd_type entry_ff [sfr_pkg::QDEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == DepthC);
   assign avail    = (count_ff != '0);
   assign pop_data = entry_ff[rptr_ff];

   // Pointer and fill count update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == LastP) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == LastP) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wptr_ff] <= push_data;
   end

endmodule

[design/sfr_back.sv]
// Back end: payload store, replay sequencer and result register.
module sfr_back #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF,
   parameter int AW          = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_avail,
   input  sfr_pkg::cmd_type            cmd_data,
   output logic                        cmd_pop,
   output logic                        replay_done,
   input  logic                        mem_we,
   input  logic [AW-1:0]               mem_waddr,
   input  logic [sfr_pkg::BYTE_W-1:0]  mem_wdata,
   sfr_rsp_if.source                   rsp
);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_SEND = 2'b10
   } bstate_type;

   logic [sfr_pkg::BYTE_W-1:0] store_mem [MAX_PAYLOAD];

   bstate_type                  state_ff, state_in;
   logic [AW-1:0]               ridx_ff, ridx_in;
   logic [sfr_pkg::LEN_W-1:0]   cnt_ff, cnt_in;
   logic [sfr_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [sfr_pkg::BYTE_W-1:0]  rdata_ff;
   logic                        ovalid_ff, ovalid_in;
   logic [sfr_pkg::BYTE_W-1:0]  obyte_ff, obyte_in;
   logic                        olast_ff, olast_in;
   logic [sfr_pkg::ST_W-1:0]    ostat_ff, ostat_in;
   logic                        out_free;
   logic                        load;
   logic                        is_end;

   assign out_free = !ovalid_ff || rsp.ready;
   assign is_end   = ((cnt_ff + 1'b1) == len_ff);

   assign rsp.valid        = ovalid_ff;
   assign rsp.payload_byte = obyte_ff;
   assign rsp.is_last      = olast_ff;
   assign rsp.status       = ostat_ff;

   // Replay sequencer; the store read runs one address ahead
   always_comb begin
      state_in    = state_ff;
      ridx_in     = ridx_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      cmd_pop     = 1'b0;
      replay_done = 1'b0;
      load        = 1'b0;
      obyte_in    = obyte_ff;
      olast_in    = olast_ff;
      ostat_in    = ostat_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (cmd_avail && out_free) begin
               cmd_pop = 1'b1;
               if (cmd_data.status == sfr_pkg::ST_GOOD) begin
                  state_in = B_SEND;
                  ridx_in  = '0;
                  cnt_in   = '0;
                  len_in   = cmd_data.len;
               end else begin
                  load     = 1'b1;
                  obyte_in = '0;
                  olast_in = 1'b1;
                  ostat_in = cmd_data.status;
               end
            end
         end
         B_SEND: begin
            if (out_free) begin
               load     = 1'b1;
               obyte_in = rdata_ff;
               olast_in = is_end;
               ostat_in = sfr_pkg::ST_GOOD;
               ridx_in  = ridx_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               if (is_end) begin
                  state_in    = B_IDLE;
                  replay_done = 1'b1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase

      ovalid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : ovalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         ovalid_ff <= 1'b0;
         cnt_ff    <= '0;
         len_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
      end
   end

   // Result payload and read index
   always_ff @(posedge clock) begin
      ridx_ff  <= ridx_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      ostat_ff <= ostat_in;
   end

   // Payload store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= store_mem[ridx_in];
   end

endmodule

[design/struct_frame_receiver.sv]
// Frame receiver top level: front end, command queue and replay back end.
// An error result passes through the command queue and the result register.
// A good frame's first byte passes the queue, store read and result registers.
// Throughput: one word in per cycle unless stalled, one out while rsp is ready.
// The front end stalls while a good payload replays or the command queue is full.
// Reset (synchronous, active high) returns to the header hunt, length 8.
module struct_frame_receiver #(
   parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   sfr_req_if.sink                   req_chan,
   sfr_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [sfr_pkg::LEN_W-1:0] csr_wdata
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic                       cmd_push;
   logic                       cmd_full;
   logic                       cmd_pop;
   logic                       cmd_avail;
   sfr_pkg::cmd_type           push_data;
   sfr_pkg::cmd_type           pop_data;
   logic                       replay_done;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [sfr_pkg::BYTE_W-1:0] mem_wdata;

   sfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd_push    (cmd_push),
      .cmd_data    (push_data),
      .cmd_full    (cmd_full),
      .replay_done (replay_done),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata)
   );

   sfr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .avail     (cmd_avail),
      .pop_data  (pop_data)
   );

   sfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_avail   (cmd_avail),
      .cmd_data    (pop_data),
      .cmd_pop     (cmd_pop),
      .replay_done (replay_done),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .rsp         (rsp_chan)
   );

endmodule

[test/struct_frame_receiver_tb.sv]
// Testbench of the frame receiver: byte streams checked against a deframer model in the bench.
module struct_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BYTES     = sfr_pkg::MAX_PAYLOAD_DEF;
   localparam int STORE_AW      = $clog2(MAX_BYTES);
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_FILL   = -1;

   typedef enum logic [4:0] {
      HUNT_FIRST  = 5'b00001,
      HUNT_SECOND = 5'b00010,
      WAIT_LEN    = 5'b00100,
      TAKE_DATA   = 5'b01000,
      WAIT_CSUM   = 5'b10000
   } frame_phase_type;

   typedef struct packed {
      logic [sfr_pkg::BYTE_W-1:0] data;
      logic                       last;
      logic [sfr_pkg::ST_W-1:0]   status;
   } rsp_word_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [sfr_pkg::LEN_W-1:0] csr_wdata;

   sfr_req_if req_chan ();
   sfr_rsp_if rsp_chan ();

   struct_frame_receiver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Deframer state kept by the bench
   logic [sfr_pkg::LEN_W-1:0]  frame_len;
   frame_phase_type            frame_phase;
   logic [sfr_pkg::LEN_W-1:0]  frame_count;
   logic [sfr_pkg::BYTE_W-1:0] frame_xor;
   logic [sfr_pkg::BYTE_W-1:0] frame_store [MAX_BYTES];
   rsp_word_type               expected_q [$];

   // Run statistics
   int mismatch_count = 0;
   int words_sent     = 0;
   int results_seen   = 0;
   int good_frames    = 0;
   int csum_errors    = 0;
   int len_errors     = 0;
   int lengths_set    = 0;
   int burst_left     = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: ERROR %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic restart_hunt();
      frame_phase = HUNT_FIRST;
      frame_count = '0;
      frame_xor   = '0;
   endtask

   // Advance the deframer by one received word and queue the results it causes
   task automatic deframe_word(input logic [sfr_pkg::BYTE_W-1:0] b);
      logic len_ok;
      len_ok = (frame_len >= 1) && (frame_len <= MAX_BYTES);
      case (frame_phase)
         HUNT_FIRST: begin
            if (b == sfr_pkg::HDR_FIRST) frame_phase = HUNT_SECOND;
         end
         HUNT_SECOND: begin
            frame_phase = (b == sfr_pkg::HDR_SECOND) ? WAIT_LEN : HUNT_FIRST;
         end
         WAIT_LEN: begin
            if (len_ok && b == {1'b0, frame_len}) begin
               frame_phase = TAKE_DATA;
               frame_count = '0;
               frame_xor   = b;
            end else begin
               expected_q.push_back('{data: '0, last: 1'b1, status: sfr_pkg::ST_LEN_ERR});
               restart_hunt();
            end
         end
         TAKE_DATA: begin
            frame_store[frame_count[STORE_AW-1:0]] = b;
            frame_xor   = frame_xor ^ b;
            frame_count = frame_count + 1'b1;
            if (frame_count >= frame_len) frame_phase = WAIT_CSUM;
         end
         WAIT_CSUM: begin
            if (b == frame_xor && len_ok) begin
               for (int i = 0; i < frame_len; i++)
                  expected_q.push_back('{data: frame_store[i], last: (i + 1 == frame_len),
                                         status: sfr_pkg::ST_GOOD});
            end else begin
               expected_q.push_back('{data: '0, last: 1'b1, status: sfr_pkg::ST_CSUM_ERR});
            end
            restart_hunt();
         end
         default: restart_hunt();
      endcase
   endtask

   // Send one word; bursts of random length with random gaps between them
   task automatic send_word(input logic [sfr_pkg::BYTE_W-1:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      deframe_word(b);
      words_sent++;
      burst_left--;
   endtask

   // Hold the sender off until every expected result is out and the block settles
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_payload_length(input logic [sfr_pkg::LEN_W-1:0] len);
      wait_results_drained();
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we    <= 1'b0;
      frame_len = len;
      restart_hunt();
      lengths_set++;
   endtask

   // Header, length word, payload and checksum; no payload or checksum after a rejected length
   task automatic send_frame(input int len_field, input int fill, input bit corrupt);
      logic [sfr_pkg::BYTE_W-1:0] sum;
      logic [sfr_pkg::BYTE_W-1:0] pb;
      send_word(sfr_pkg::HDR_FIRST);
      send_word(sfr_pkg::HDR_SECOND);
      send_word(len_field[sfr_pkg::BYTE_W-1:0]);
      if (len_field != frame_len || frame_len == 0 || frame_len > MAX_BYTES) return;
      sum = len_field[sfr_pkg::BYTE_W-1:0];
      for (int i = 0; i < len_field; i++) begin
         pb  = (fill == RANDOM_FILL) ? sfr_pkg::BYTE_W'($urandom)
                                     : fill[sfr_pkg::BYTE_W-1:0];
         sum = sum ^ pb;
         send_word(pb);
      end
      if (corrupt) sum = sum ^ sfr_pkg::BYTE_W'($urandom_range(1, 255));
      send_word(sum);
   endtask

   // Wrong second header byte is consumed, not retested; then a frame at reset length
   task automatic test_header_hunt();
      send_word(sfr_pkg::HDR_FIRST);
      send_word(sfr_pkg::HDR_FIRST);
      send_word(sfr_pkg::HDR_SECOND);
      send_frame(sfr_pkg::LEN_RESET, RANDOM_FILL, 1'b0);
   endtask

   // A length write in the middle of a payload drops the frame
   task automatic test_abort_mid_frame();
      write_payload_length(7'd2);
      send_word(sfr_pkg::HDR_FIRST);
      send_word(sfr_pkg::HDR_SECOND);
      send_word(8'd2);
      send_word(8'hAA);
      write_payload_length(7'd1);
   endtask

   // Shortest frames: all-ones payload, then all-zeros with a bad checksum
   task automatic test_short_frames();
      send_frame(1, 8'hFF, 1'b0);
      send_frame(1, 8'h00, 1'b1);
   endtask

   // Length settings outside 1..64 reject every length word
   task automatic test_length_out_of_range();
      write_payload_length(7'd0);
      send_frame(0, RANDOM_FILL, 1'b0);
      write_payload_length(7'd127);
      send_frame(127, RANDOM_FILL, 1'b0);
   endtask

   // Mostly good frames with random content, plus bad checksums, bad lengths and noise
   task automatic test_random_traffic();
      int          settings [6];
      int          phase_end;
      int          pick;
      int          len_field;
      int          noise_len;
      bit          first;
      settings = '{4, 64, 1, 0, 8, 8};
      settings[3] = $urandom_range(65, 127);
      settings[4] = $urandom_range(2, 12);
      foreach (settings[s]) begin
         write_payload_length(settings[s][sfr_pkg::LEN_W-1:0]);
         phase_end = words_sent + ((settings[s] == 64) ? 60 : 10);
         first     = 1'b1;
         while (words_sent < phase_end) begin
            pick = first ? 0 : $urandom_range(0, 9);
            first = 1'b0;
            if (pick <= 6) begin
               send_frame(settings[s], RANDOM_FILL, 1'b0);
            end else if (pick == 7) begin
               send_frame(settings[s], RANDOM_FILL, 1'b1);
            end else if (pick == 8) begin
               len_field = $urandom_range(0, 255);
               if (len_field == settings[s]) len_field = (len_field + 1) % 256;
               send_frame(len_field, RANDOM_FILL, 1'b0);
            end else begin
               noise_len = $urandom_range(1, 4);
               repeat (noise_len)
                  send_word(($urandom_range(0, 3) == 0) ? sfr_pkg::HDR_FIRST
                                                        : sfr_pkg::BYTE_W'($urandom));
            end
         end
      end
   endtask

   // Receiver stall pattern: always ready, coin flip, short dips, long stalls
   bit [7:0] stall_tick = '0;
   bit [1:0] stall_mode = '0;
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick[5:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_chan.ready <= 1'b1;
         2'd1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_chan.ready <= (stall_tick[2:0] > 3'd2);
         default: rsp_chan.ready <= (stall_tick[4:0] >= 5'd20);
      endcase
   end

   // Compare every accepted result word with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_seen++;
         if (rsp_chan.is_last && rsp_chan.status == sfr_pkg::ST_GOOD) good_frames++;
         if (rsp_chan.status == sfr_pkg::ST_CSUM_ERR) csum_errors++;
         if (rsp_chan.status == sfr_pkg::ST_LEN_ERR) len_errors++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result word data=%h last=%b status=%0d",
                                      rsp_chan.payload_byte, rsp_chan.is_last,
                                      rsp_chan.status));
         end else begin
            want = expected_q.pop_front();
            if (rsp_chan.payload_byte !== want.data)
               report_mismatch($sformatf("payload_byte %h, expected %h",
                                         rsp_chan.payload_byte, want.data));
            if (rsp_chan.is_last !== want.last)
               report_mismatch($sformatf("is_last %b, expected %b",
                                         rsp_chan.is_last, want.last));
            if (rsp_chan.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_chan.status, want.status));
         end
      end
   end

   // Watchdog: ends the run when no word moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t ns: no word moved for %0d cycles, %0d results still expected",
               $time, QUIET_LIMIT, expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      frame_len = sfr_pkg::LEN_RESET;
      restart_hunt();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_header_hunt();
      test_abort_mid_frame();
      test_short_frames();
      test_length_out_of_range();
      test_random_traffic();
      wait_results_drained();

      $display("Run covered %0d received words under %0d length settings, %0d result words.",
               words_sent, lengths_set, results_seen);
      $display("Seen: %0d good frames, %0d checksum errors, %0d length errors.",
               good_frames, csum_errors, len_errors);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
